// ===== rtl/pidpi_pkg.sv =====
// pidpi_pkg: shared types, codes and helper functions for the PID core.
// Used by pidpi_cfg, pidpi_dpath and pid_positional_incremental_core.
`timescale 1ns / 1ps

package pidpi_pkg;

    localparam int FRAC_BITS = 8;
    localparam int ACC_W     = 40;
    localparam int STATE_W   = 24;
    localparam int ERR_W     = 17;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 16;

    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [STATE_W-1:0] t_state;
    typedef logic signed [ERR_W-1:0]   t_err;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_OUT_LIMIT  = 3'd3,
        REG_INT_LIMIT  = 3'd4,
        REG_DEADZONE   = 3'd5,
        REG_LOOP_MODE  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_POS  = 2'd0,
        MODE_INC  = 2'd1,
        MODE_ZERO = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [14:0]        output_limit;
        logic [14:0]        integral_limit;
        logic [15:0]        deadzone;
        logic [1:0]         loop_mode;
    } t_cfg;

    function automatic t_acc clamp_sym(input t_acc v, input t_acc lim);
        t_acc r;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // truncate fraction toward zero
    function automatic t_acc trunc_int(input t_acc v);
        t_acc r;
        if (v < 0) begin
            r = -((-v) >>> FRAC_BITS);
        end else begin
            r = v >>> FRAC_BITS;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pidpi_cfg.sv =====
// pidpi_cfg: configuration register file, written through a plain write port.
// Depends on pidpi_pkg.
`timescale 1ns / 1ps

module pidpi_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pidpi_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [pidpi_pkg::CFG_W-1:0] i_cfg_data,
    output pidpi_pkg::t_cfg           o_cfg
);
    import pidpi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.output_limit   <= '0;
            r_cfg.integral_limit <= '0;
            r_cfg.deadzone       <= '0;
            r_cfg.loop_mode      <= MODE_ZERO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN_P:    r_cfg.gain_p         <= i_cfg_data;
                REG_GAIN_I:    r_cfg.gain_i         <= i_cfg_data;
                REG_GAIN_D:    r_cfg.gain_d         <= i_cfg_data;
                REG_OUT_LIMIT: r_cfg.output_limit   <= i_cfg_data[14:0];
                REG_INT_LIMIT: r_cfg.integral_limit <= i_cfg_data[14:0];
                REG_DEADZONE:  r_cfg.deadzone       <= i_cfg_data;
                REG_LOOP_MODE: r_cfg.loop_mode      <= i_cfg_data[1:0];
                default:       r_cfg                <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/pidpi_dpath.sv =====
// pidpi_dpath: per-sample PID arithmetic and the loop state (error history,
// integral, output accumulator). Depends on pidpi_pkg.
`timescale 1ns / 1ps

module pidpi_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic signed [15:0] i_measured,
    input  logic signed [15:0] i_target,
    input  pidpi_pkg::t_cfg    i_cfg,
    output logic signed [15:0] o_drive
);
    import pidpi_pkg::*;

    t_err   r_e1, r_e0;
    t_state r_integ, r_out;
    t_state n_integ, n_out;

    t_err               w_e;
    logic [ERR_W-1:0]   w_mag;
    logic signed [17:0] w_d1;
    logic signed [18:0] w_d2;
    logic signed [17:0] w_pa;
    logic signed [18:0] w_da;
    logic signed [33:0] w_pterm;
    logic signed [32:0] w_iterm;
    logic signed [34:0] w_dterm;
    t_acc w_olim, w_ilim, w_integ_c, w_sum, w_out_c, w_drive;
    logic w_inc_mode;

    assign w_e   = t_err'(i_target) - t_err'(i_measured);
    assign w_mag = w_e[ERR_W-1] ? (ERR_W)'(-w_e) : (ERR_W)'(w_e);
    assign w_d1  = w_e - r_e1;
    assign w_d2  = w_e - (r_e1 <<< 1) + r_e0;

    assign w_inc_mode = (i_cfg.loop_mode == MODE_INC);
    assign w_pa = w_inc_mode ? w_d1 : 18'(w_e);
    assign w_da = w_inc_mode ? w_d2 : 19'(w_d1);

    assign w_pterm = i_cfg.gain_p * w_pa;
    assign w_iterm = i_cfg.gain_i * w_e;
    assign w_dterm = i_cfg.gain_d * w_da;

    assign w_olim = t_acc'(i_cfg.output_limit) <<< FRAC_BITS;
    assign w_ilim = t_acc'(i_cfg.integral_limit) <<< FRAC_BITS;

    assign w_integ_c = clamp_sym(t_acc'(r_integ) + t_acc'(w_iterm), w_ilim);
    assign w_sum     = t_acc'(w_pterm) + w_integ_c + t_acc'(w_dterm);
    assign w_out_c   = clamp_sym(t_acc'(r_out) + t_acc'(w_pterm) + t_acc'(w_iterm)
                                 + t_acc'(w_dterm), w_olim);

    always_comb begin
        n_integ = r_integ;
        n_out   = r_out;
        w_drive = '0;
        case (i_cfg.loop_mode)
            MODE_POS: begin
                n_integ = STATE_W'(w_integ_c);
                w_drive = trunc_int(clamp_sym(w_sum, w_olim));
                n_out   = STATE_W'(w_drive <<< FRAC_BITS);
            end
            MODE_INC: begin
                if ({1'b0, w_mag} >= {2'b0, i_cfg.deadzone}) begin
                    n_out = STATE_W'(w_out_c);
                end
                w_drive = trunc_int(t_acc'(n_out));
            end
            default: begin
                n_out   = '0;
                w_drive = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1    <= '0;
            r_e0    <= '0;
            r_integ <= '0;
            r_out   <= '0;
        end else if (i_en) begin
            r_e0    <= r_e1;
            r_e1    <= w_e;
            r_integ <= n_integ;
            r_out   <= n_out;
        end
    end

    assign o_drive = w_drive[15:0];

endmodule

// ===== rtl/pid_positional_incremental_core.sv =====
// Positional / incremental PID controller core, one sample per request.
// Channels: input request (i_in_valid/o_in_ready, i_measured, i_target),
// result request (o_out_valid/i_out_ready, o_drive), and a plain config
// write port (i_cfg_we, i_cfg_idx, i_cfg_data), which the user must write
// only while idle; the block itself does not enforce this. An accepted
// sample lands in an input register; once the result register is free or
// being taken, the datapath evaluates it against the loop state and the
// result register loads drive while the state updates.
// Throughput: one sample per cycle while the receiver takes each result;
// the loop state recurrence (integral and output accumulator through
// multiply, add and clamp) is combinational between the state registers.
// Stalls: while the result register is held, the input register keeps its
// sample, and one more request is still taken if the input register is
// free; then o_in_ready drops until the receiver takes the result.
// Reset: synchronous, active low; clears both valid flags, the loop state
// and the config registers (loop_mode resets to zero-output mode).
// Depends on pidpi_pkg, pidpi_cfg and pidpi_dpath.
`timescale 1ns / 1ps

module pid_positional_incremental_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pidpi_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [pidpi_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [15:0]          i_measured,
    input  logic signed [15:0]          i_target,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [15:0]          o_drive
);
    import pidpi_pkg::*;

    t_cfg w_cfg;

    logic               r_in_valid;
    logic signed [15:0] r_measured, r_target;
    logic               r_out_valid;
    logic signed [15:0] r_drive;
    logic signed [15:0] w_drive;
    logic               w_adv;

    pidpi_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    pidpi_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_measured (r_measured),
        .i_target   (r_target),
        .i_cfg      (w_cfg),
        .o_drive    (w_drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_measured <= i_measured;
            r_target   <= i_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_drive <= w_drive;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive != 16'sh8000))
        else $error("drive outside symmetric range");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |-> !o_in_ready)
        else $error("input register overwritten while stalled");

    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("evaluated sample produced no result");

    a_stall_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_drive)))
        else $error("pending result lost under stall");

endmodule

// ===== tb/sv/pid_positional_incremental_core_tb.sv =====
// Self-checking testbench for pid_positional_incremental_core: a fixed-point
// model of the PID law predicts every drive value and each result is checked in order.
// Depends on pidpi_pkg and the core RTL.
`timescale 1ns / 1ps

module pid_positional_incremental_core_tb;

    import pidpi_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [IDX_W-1:0]     i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [15:0]   i_measured;
    logic signed [15:0]   i_target;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [15:0]   o_drive;

    pid_positional_incremental_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_measured  (i_measured),
        .i_target    (i_target),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive)
    );

    // register mirror
    logic signed [15:0]   cfg_kp, cfg_ki, cfg_kd;
    logic [14:0]          cfg_olim, cfg_ilim;
    logic [15:0]          cfg_dband;
    logic [1:0]           cfg_mode;

    // loop state mirror
    logic signed [ERR_W-1:0]   err_last, err_prev;
    logic signed [STATE_W-1:0] integ_acc, out_acc;

    logic signed [15:0]   drive_expect_q[$];
    int                   mismatch_count = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   hold_cycles    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint limit_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint to_whole(input longint v);
        if (v < 0) return -((-v) >> FRAC_BITS);
        return v >> FRAC_BITS;
    endfunction

    // advances the loop state by one sample and returns the drive it yields
    function automatic logic signed [15:0] pid_law(input logic signed [15:0] meas,
                                                   input logic signed [15:0] tgt);
        longint kp, ki, kd, olim, ilim, err, e1, e0, sum, mag, step, acc, drv;
        kp   = longint'(cfg_kp);
        ki   = longint'(cfg_ki);
        kd   = longint'(cfg_kd);
        olim = longint'(cfg_olim) * (longint'(1) << FRAC_BITS);
        ilim = longint'(cfg_ilim) * (longint'(1) << FRAC_BITS);
        err  = longint'(tgt) - longint'(meas);
        e1   = longint'(err_last);
        e0   = longint'(err_prev);
        drv  = 0;
        err_prev = err_last;
        err_last = err[ERR_W-1:0];
        if (cfg_mode == MODE_POS) begin
            acc       = limit_sym(longint'(integ_acc) + ki * err, ilim);
            integ_acc = acc[STATE_W-1:0];
            sum       = kp * err + acc + kd * (err - e1);
            drv       = to_whole(limit_sym(sum, olim));
            acc       = drv * (longint'(1) << FRAC_BITS);
            out_acc   = acc[STATE_W-1:0];
        end else if (cfg_mode == MODE_INC) begin
            mag = (err < 0) ? -err : err;
            if (mag >= longint'(cfg_dband)) begin
                step    = kp * (err - e1) + ki * err + kd * (err - 2 * e1 + e0);
                acc     = limit_sym(longint'(out_acc) + step, olim);
                out_acc = acc[STATE_W-1:0];
            end
            drv = to_whole(longint'(out_acc));
        end else begin
            out_acc = '0;
        end
        return drv[15:0];
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3, 4:    return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 1536)) - 768);
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        logic [14:0] lim;
        case ($urandom_range(0, 5))
            0:       lim = 15'd0;
            1:       lim = 15'h7fff;
            2, 3:    lim = 15'($urandom);
            default: lim = 15'($urandom_range(0, 2000));
        endcase
        return {1'($urandom), lim};
    endfunction

    function automatic logic [15:0] pick_band();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 40));
        endcase
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_GAIN_P:    cfg_kp    = val;
            REG_GAIN_I:    cfg_ki    = val;
            REG_GAIN_D:    cfg_kd    = val;
            REG_OUT_LIMIT: cfg_olim  = val[14:0];
            REG_INT_LIMIT: cfg_ilim  = val[14:0];
            REG_DEADZONE:  cfg_dband = val;
            REG_LOOP_MODE: cfg_mode  = val[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_sample(input logic signed [15:0] meas, input logic signed [15:0] tgt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_measured <= meas;
        i_target   <= tgt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        drive_expect_q.push_back(pid_law(meas, tgt));
        @(negedge i_clk);
    endtask

    task automatic send_random_sample();
        logic signed [15:0] meas, tgt;
        tgt = 16'($urandom);
        case ($urandom_range(0, 3))
            0: meas = 16'($urandom);
            1, 2: meas = tgt + 16'($signed($urandom_range(0, 64)) - 32);
            default: begin
                meas = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
                tgt  = $urandom_range(0, 1) ? 16'sh8000 : ($urandom_range(0, 1) ? 16'sh7fff : 16'sh0);
            end
        endcase
        send_sample(meas, tgt);
    endtask

    // drop valid, wait for every result, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (drive_expect_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic randomize_config();
        int r;
        settle();
        write_reg(REG_GAIN_P, pick_gain());
        write_reg(REG_GAIN_I, pick_gain());
        write_reg(REG_GAIN_D, pick_gain());
        write_reg(REG_OUT_LIMIT, pick_limit());
        write_reg(REG_INT_LIMIT, pick_limit());
        write_reg(REG_DEADZONE, pick_band());
        r = $urandom_range(0, 9);
        if (r < 4)      write_reg(REG_LOOP_MODE, {14'($urandom), MODE_POS});
        else if (r < 8) write_reg(REG_LOOP_MODE, {14'($urandom), MODE_INC});
        else if (r < 9) write_reg(REG_LOOP_MODE, {14'($urandom), MODE_ZERO});
        else            write_reg(REG_LOOP_MODE, {14'($urandom), MODE_UNUSED});
    endtask

    task automatic test_zero_mode_after_reset();
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh0000, 16'sh0000);
    endtask

    task automatic test_positional();
        settle();
        write_reg(REG_GAIN_P, 16'h0100);
        write_reg(REG_GAIN_I, 16'h7fff);
        write_reg(REG_GAIN_D, 16'h8000);
        write_reg(REG_OUT_LIMIT, 16'h7fff);
        write_reg(REG_INT_LIMIT, 16'h7fff);
        write_reg(REG_LOOP_MODE, {14'd0, MODE_POS});
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh0010, 16'sh0013);
        send_sample(16'sh0000, 16'sh0000);
        settle();
        write_reg(REG_OUT_LIMIT, 16'h0000);
        write_reg(REG_INT_LIMIT, 16'h0000);
        send_sample(16'sh0000, 16'sh0100);
        send_sample(16'sh0100, 16'sh0000);
        settle();
        write_reg(REG_GAIN_P, 16'h8000);
        write_reg(REG_GAIN_I, 16'h8000);
        write_reg(REG_OUT_LIMIT, 16'd100);
        write_reg(REG_INT_LIMIT, 16'd50);
        send_sample(16'sh0000, 16'sh0001);
        send_sample(16'sh0001, 16'sh0000);
    endtask

    task automatic test_incremental();
        settle();
        write_reg(REG_GAIN_P, 16'h0080);
        write_reg(REG_GAIN_I, 16'h0040);
        write_reg(REG_GAIN_D, 16'h0020);
        write_reg(REG_OUT_LIMIT, 16'd1000);
        write_reg(REG_DEADZONE, 16'd0);
        write_reg(REG_LOOP_MODE, {14'd0, MODE_INC});
        send_sample(16'sh0000, 16'sh0005);
        send_sample(16'sh0000, -16'sh0003);
        settle();
        write_reg(REG_DEADZONE, 16'd10);
        send_sample(16'sh0000, 16'sh000a);   // at the band edge
        send_sample(16'sh0000, 16'sh0009);   // just inside the band
        send_sample(16'sh000a, 16'sh0000);
        settle();
        write_reg(REG_DEADZONE, 16'hffff);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh0000, 16'sh7fff);
    endtask

    task automatic test_unused_mode();
        settle();
        write_reg(REG_LOOP_MODE, {14'd0, MODE_UNUSED});
        send_sample(16'sh1234, -16'sh1234);
        send_sample(16'sh0000, 16'sh0001);
    endtask

    task automatic test_input_backpressure();
        settle();
        write_reg(REG_GAIN_P, 16'h0180);
        write_reg(REG_GAIN_I, 16'h0010);
        write_reg(REG_GAIN_D, 16'h0040);
        write_reg(REG_OUT_LIMIT, 16'd20000);
        write_reg(REG_INT_LIMIT, 16'd5000);
        write_reg(REG_LOOP_MODE, {14'd0, MODE_POS});
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_cycles = 300;
        @(negedge i_clk);
        repeat (30) send_random_sample();
        settle();
        repeat (10) send_random_sample();
        settle();
    endtask

    task automatic test_random_traffic();
        int idle_tab[4]  = '{0, 81, 0, 22};
        int stall_tab[4] = '{0, 0, 81, 22};
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 5; k++) begin
                randomize_config();
                send_idle_pct  = idle_tab[ph];
                recv_stall_pct = stall_tab[ph];
                repeat (90) send_random_sample();
            end
        end
        settle();
    endtask

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (drive_expect_q.size() == 0) begin
                $display("%0t unexpected drive request: expected none actual %0d", $time, o_drive);
                mismatch_count++;
            end else begin
                want = drive_expect_q.pop_front();
                if (o_drive !== want) begin
                    $display("%0t drive mismatch: expected %0d actual %0d", $time, want, o_drive);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_GAIN_P;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_measured  = '0;
        i_target    = '0;
        i_out_ready = 1'b0;
        cfg_kp = '0; cfg_ki = '0; cfg_kd = '0;
        cfg_olim = '0; cfg_ilim = '0; cfg_dband = '0;
        cfg_mode = MODE_ZERO;
        err_last = '0; err_prev = '0; integ_acc = '0; out_acc = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_zero_mode_after_reset();
        test_positional();
        test_incremental();
        test_unused_mode();
        test_input_backpressure();
        test_random_traffic();

        settle();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0 && drive_expect_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
